>>> sv/qdda_pkg.sv
// shared types, constants and tables for the quadrature detent decoder
package qdda_pkg;

    // command codes
    localparam logic [1:0] CMD_POLL = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_ZERO = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENCODER_TYPE     = 3'd0;
    localparam logic [2:0] REG_FAST_TRIGGER     = 3'd1;
    localparam logic [2:0] REG_FAST_SPEED       = 3'd2;
    localparam logic [2:0] REG_POSITION_LIMIT   = 3'd3;
    localparam logic [2:0] REG_DECAY_MS         = 3'd4;
    localparam logic [2:0] REG_IDLE_MS          = 3'd5;
    localparam logic [2:0] REG_DETENT_COUNT_MAX = 3'd6;

    // configuration reset values
    localparam logic [2:0]  RST_ENCODER_TYPE     = 3'd2;
    localparam logic [3:0]  RST_FAST_TRIGGER     = 4'd4;
    localparam logic [3:0]  RST_FAST_SPEED       = 4'd4;
    localparam logic [14:0] RST_POSITION_LIMIT   = 15'd32000;
    localparam logic [15:0] RST_DECAY_MS         = 16'd100;
    localparam logic [15:0] RST_IDLE_MS          = 16'd500;
    localparam logic [3:0]  RST_DETENT_COUNT_MAX = 4'd12;

    localparam logic [31:0] RST_STEP_TIME = 32'd500;

    localparam logic [2:0] LAST_ENCODER_TYPE = 3'd4;

    // step direction codes
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_UP   = 2'b01;
    localparam logic [1:0] DIR_DOWN = 2'b11;

    // indexed by {previous state, new state}
    localparam logic [1:0] STEP_DIR [16] = '{
        DIR_NONE, DIR_DOWN, DIR_UP,   DIR_NONE,
        DIR_UP,   DIR_NONE, DIR_NONE, DIR_DOWN,
        DIR_DOWN, DIR_NONE, DIR_NONE, DIR_UP,
        DIR_NONE, DIR_UP,   DIR_DOWN, DIR_NONE
    };

    // detent states per encoder type, one bit per quadrature state
    localparam logic [3:0] TYPE_DETENTS [5] = '{4'h8, 4'h1, 4'h9, 4'h6, 4'hF};
    localparam logic [1:0] TYPE_SHIFT [5]   = '{2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

    typedef struct packed {
        logic [2:0]  encoder_type;
        logic [3:0]  fast_trigger;
        logic [3:0]  fast_speed;
        logic [14:0] position_limit;
        logic [15:0] decay_ms;
        logic [15:0] idle_ms;
        logic [3:0]  detent_count_max;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  prev_quad;
        logic [17:0] raw_position;
        logic [15:0] ext_position;
        logic [15:0] reported_position;
        logic [31:0] delta_acc;
        logic [3:0]  detent_count;
        logic [31:0] last_decay_ms;
        logic [31:0] step_time_prev;
        logic [31:0] step_time;
    } state_t;

    typedef struct packed {
        logic [1:0]  command;
        logic        pin_a;
        logic        pin_b;
        logic [31:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [15:0] position;
        logic [31:0] delta;
        logic        moved;
        logic        limit_reset;
    } result_t;

endpackage

>>> sv/qdda_cfg.sv
// configuration register file for the quadrature detent decoder
module qdda_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    output qdda_pkg::cfg_t   cfg
);

    qdda_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.encoder_type     <= qdda_pkg::RST_ENCODER_TYPE;
            cfg_reg.fast_trigger     <= qdda_pkg::RST_FAST_TRIGGER;
            cfg_reg.fast_speed       <= qdda_pkg::RST_FAST_SPEED;
            cfg_reg.position_limit   <= qdda_pkg::RST_POSITION_LIMIT;
            cfg_reg.decay_ms         <= qdda_pkg::RST_DECAY_MS;
            cfg_reg.idle_ms          <= qdda_pkg::RST_IDLE_MS;
            cfg_reg.detent_count_max <= qdda_pkg::RST_DETENT_COUNT_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                qdda_pkg::REG_ENCODER_TYPE:     cfg_reg.encoder_type     <= cfg_data[2:0];
                qdda_pkg::REG_FAST_TRIGGER:     cfg_reg.fast_trigger     <= cfg_data[3:0];
                qdda_pkg::REG_FAST_SPEED:       cfg_reg.fast_speed       <= cfg_data[3:0];
                qdda_pkg::REG_POSITION_LIMIT:   cfg_reg.position_limit   <= cfg_data[14:0];
                qdda_pkg::REG_DECAY_MS:         cfg_reg.decay_ms         <= cfg_data;
                qdda_pkg::REG_IDLE_MS:          cfg_reg.idle_ms          <= cfg_data;
                qdda_pkg::REG_DETENT_COUNT_MAX: cfg_reg.detent_count_max <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> sv/qdda_step.sv
// next-state and result logic for one item of the quadrature detent decoder
module qdda_step (
    input  qdda_pkg::item_t   item,
    input  qdda_pkg::state_t  st,
    input  qdda_pkg::cfg_t    cfg,
    output qdda_pkg::state_t  st_next,
    output qdda_pkg::result_t res
);

    logic [2:0]         enc_type;
    logic [1:0]         quad;
    logic [31:0]        since_decay;
    logic [31:0]        since_step;
    logic [3:0]         cnt;
    logic [31:0]        last_decay;
    logic [3:0]         speed;
    logic [5:0]         step_mag;
    logic [1:0]         dir;
    logic [17:0]        raw_stepped;
    logic [4:0]         cnt_inc;
    logic [3:0]         cnt_capped;
    logic               is_detent;
    logic               changed;
    logic [1:0]         shift;

    // values after the decode of a poll
    logic [17:0]        raw_dec;
    logic [15:0]        ext_dec;
    logic [3:0]         cnt_dec;
    logic [31:0]        stp_prev_dec;
    logic [31:0]        stp_dec;

    logic [15:0]        d;
    logic signed [17:0] sum;
    logic signed [17:0] lim_pos;
    logic signed [17:0] lim_neg;
    logic               d_pos;
    logic               d_neg;
    logic               over;

    always_comb
    begin
        enc_type = (cfg.encoder_type > qdda_pkg::LAST_ENCODER_TYPE)
                   ? qdda_pkg::LAST_ENCODER_TYPE : cfg.encoder_type;
        quad = {~item.pin_b, ~item.pin_a};
        since_decay = item.now_ms - st.last_decay_ms;
        since_step  = item.now_ms - st.step_time_prev;

        // counter decay, else clear after idle time
        cnt = st.detent_count;
        last_decay = st.last_decay_ms;
        if (since_decay > {16'd0, cfg.decay_ms} && st.detent_count > 4'd1)
        begin
            last_decay = item.now_ms;
            cnt = st.detent_count - 4'd1;
        end
        else if (since_step > {16'd0, cfg.idle_ms})
        begin
            last_decay = item.now_ms;
            cnt = 4'd0;
        end

        speed = (cnt > cfg.fast_trigger) ? cfg.fast_speed : 4'd1;
        shift = qdda_pkg::TYPE_SHIFT[enc_type];
        step_mag = {2'b00, speed} << shift;
        dir = qdda_pkg::STEP_DIR[{st.prev_quad, quad}];
        case (dir)
            qdda_pkg::DIR_UP:   raw_stepped = st.raw_position + {12'd0, step_mag};
            qdda_pkg::DIR_DOWN: raw_stepped = st.raw_position - {12'd0, step_mag};
            default:            raw_stepped = st.raw_position;
        endcase

        changed = (quad != st.prev_quad);
        is_detent = qdda_pkg::TYPE_DETENTS[enc_type][quad];
        cnt_inc = {1'b0, cnt} + 5'd1;
        cnt_capped = (cnt_inc < {1'b0, cfg.detent_count_max})
                     ? cnt_inc[3:0] : cfg.detent_count_max;

        raw_dec = st.raw_position;
        ext_dec = st.ext_position;
        cnt_dec = cnt;
        stp_prev_dec = st.step_time_prev;
        stp_dec = st.step_time;
        if (changed)
        begin
            raw_dec = raw_stepped;
            if (is_detent)
            begin
                stp_prev_dec = st.step_time;
                stp_dec = item.now_ms;
                ext_dec = raw_stepped[17:2];
                cnt_dec = cnt_capped;
            end
        end

        // position change against the last reported value, 16-bit wrap
        d = ext_dec - st.reported_position;
        d_pos = !d[15] && (d != 16'd0);
        d_neg = d[15];
        sum = $signed({{2{ext_dec[15]}}, ext_dec}) + $signed({d[15], d, 1'b0});
        lim_pos = $signed({3'b000, cfg.position_limit});
        lim_neg = -lim_pos;
        over = (d_pos && (sum > lim_pos)) || (d_neg && (sum < lim_neg));

        st_next = st;
        res.position = st.ext_position;
        res.delta = 32'd0;
        res.moved = 1'b0;
        res.limit_reset = 1'b0;

        case (item.command)
            qdda_pkg::CMD_POLL:
            begin
                st_next.prev_quad = quad;
                st_next.raw_position = raw_dec;
                st_next.ext_position = ext_dec;
                st_next.detent_count = cnt_dec;
                st_next.last_decay_ms = last_decay;
                st_next.step_time_prev = stp_prev_dec;
                st_next.step_time = stp_dec;
                res.position = ext_dec;
                if (d != 16'd0)
                begin
                    res.moved = 1'b1;
                    st_next.delta_acc = st.delta_acc + {{16{d[15]}}, d};
                    st_next.reported_position = ext_dec;
                    if (over)
                    begin
                        st_next.raw_position = {16'd0, raw_dec[1:0]};
                        st_next.ext_position = 16'd0;
                        st_next.reported_position = 16'd0;
                        res.position = 16'd0;
                        res.limit_reset = 1'b1;
                    end
                end
            end
            qdda_pkg::CMD_READ:
            begin
                res.delta = st.delta_acc;
                st_next.delta_acc = 32'd0;
            end
            qdda_pkg::CMD_ZERO:
            begin
                st_next.raw_position = {16'd0, st.raw_position[1:0]};
                st_next.ext_position = 16'd0;
                res.position = 16'd0;
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> sv/quadrature_detent_decoder_accel.sv
// top level of the quadrature detent decoder with acceleration
// an accepted item waits in the input register until the result register frees
// throughput: one item per cycle unless results stall; the state update of an
// item fits between input and result register, so the next item uses it at once
// reset: all state and configuration registers take their reset values at once
module quadrature_detent_decoder_accel (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic               pin_a,
    input  logic               pin_b,
    input  logic [31:0]        now_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] position,
    output logic signed [31:0] delta,
    output logic               moved,
    output logic               limit_reset
);

    qdda_pkg::cfg_t    cfg;
    qdda_pkg::item_t   item_reg;
    logic              in_valid_reg;
    qdda_pkg::state_t  state_reg;
    qdda_pkg::state_t  state_next;
    qdda_pkg::result_t result_reg;
    qdda_pkg::result_t result_next;
    logic              out_valid_reg;
    logic              advance;

    qdda_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    qdda_step u_step (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (result_next)
    );

    // the result register frees when it is empty or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.command <= command;
            item_reg.pin_a   <= pin_a;
            item_reg.pin_b   <= pin_b;
            item_reg.now_ms  <= now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_quad         <= 2'd0;
            state_reg.raw_position      <= 18'd0;
            state_reg.ext_position      <= 16'd0;
            state_reg.reported_position <= 16'd0;
            state_reg.delta_acc         <= 32'd0;
            state_reg.detent_count      <= 4'd0;
            state_reg.last_decay_ms     <= 32'd0;
            state_reg.step_time_prev    <= 32'd0;
            state_reg.step_time         <= qdda_pkg::RST_STEP_TIME;
            out_valid_reg               <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign position    = $signed(result_reg.position);
    assign delta       = $signed(result_reg.delta);
    assign moved       = result_reg.moved;
    assign limit_reset = result_reg.limit_reset;

    // overflow protection always leaves the position at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && limit_reset |-> (position == 16'sd0) && moved)
    else $error("limit reset without zero position or movement");

    // a read item leaves the accumulator cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_valid_reg && (item_reg.command == qdda_pkg::CMD_READ)
        |=> (state_reg.delta_acc == 32'd0))
    else $error("delta accumulator not cleared by read");

    // input side stalls only behind a held result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && in_valid_reg)
    else $error("input stalled without a held result");

    // state only moves when an item is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && in_valid_reg) |=> $stable(state_reg))
    else $error("state changed without an item");

endmodule

>>> verif/tb_quadrature_detent_decoder_accel.sv
// testbench for the quadrature detent decoder: directed table, random turns, self-checking
`timescale 1ns / 1ps

module tb_quadrature_detent_decoder_accel;
    import qdda_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;
    localparam result_t NO_CHANGE = '0;

    typedef struct packed {
        item_t   stim;
        logic    known;
        result_t want;
    } row_t;

    typedef struct packed {
        logic    known;
        result_t want;
    } note_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         command = CMD_POLL;
    logic               pin_a = 1'b1;
    logic               pin_b = 1'b1;
    logic [31:0]        now_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] position;
    logic signed [31:0] delta;
    logic               moved;
    logic               limit_reset;

    quadrature_detent_decoder_accel DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .pin_a       (pin_a),
        .pin_b       (pin_b),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .position    (position),
        .delta       (delta),
        .moved       (moved),
        .limit_reset (limit_reset)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // direction of one quadrature move, indexed by {old state, new state}
    int quad_turn [16] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
    logic [3:0] detent_masks [5] = '{4'h8, 4'h1, 4'h9, 4'h6, 4'hF};
    int res_shift [5] = '{2, 2, 1, 1, 0};
    logic [1:0] cw_next [4] = '{2'd2, 2'd0, 2'd3, 2'd1};
    logic [1:0] ccw_next [4] = '{2'd1, 2'd3, 2'd0, 2'd2};

    // mirror of the block's configuration and state
    cfg_t ctrl = '{RST_ENCODER_TYPE, RST_FAST_TRIGGER, RST_FAST_SPEED, RST_POSITION_LIMIT,
                   RST_DECAY_MS, RST_IDLE_MS, RST_DETENT_COUNT_MAX};
    logic [1:0]  quad_prev = '0;
    logic [17:0] raw_pos = '0;
    logic [15:0] ext_pos = '0;
    logic [15:0] rep_pos = '0;
    logic [31:0] delta_sum = '0;
    logic [3:0]  det_cnt = '0;
    logic [31:0] decay_stamp = '0;
    logic [31:0] step_stamp_prev = '0;
    logic [31:0] step_stamp = RST_STEP_TIME;

    note_t   typed_answers [$];
    result_t pending_readings [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      eager_left = 0;
    bit      sender_run = 1'b0;
    bit      recv_run = 1'b0;
    bit      hold_off_req = 1'b0;
    logic [1:0]  cur_q = '0;
    logic [31:0] wall_ms = '0;

    function automatic result_t advance_encoder(input item_t it);
        logic [2:0]         kind;
        logic [1:0]         q;
        logic [4:0]         bumped;
        logic signed [15:0] pos;
        logic signed [15:0] rep;
        logic signed [15:0] d;
        int                 spd;
        int                 mv;
        int                 reach;
        result_t            r;
        r = '0;
        case (it.command)
            CMD_POLL:
            begin
                kind = (ctrl.encoder_type > LAST_ENCODER_TYPE) ? LAST_ENCODER_TYPE
                                                               : ctrl.encoder_type;
                q = {~it.pin_b, ~it.pin_a};
                // counter decays one step per interval, clears once idle
                if (it.now_ms - decay_stamp > {16'd0, ctrl.decay_ms} && det_cnt > 4'd1)
                begin
                    decay_stamp = it.now_ms;
                    det_cnt = det_cnt - 4'd1;
                end
                else if (it.now_ms - step_stamp_prev > {16'd0, ctrl.idle_ms})
                begin
                    decay_stamp = it.now_ms;
                    det_cnt = '0;
                end
                if (q != quad_prev)
                begin
                    spd = (det_cnt > ctrl.fast_trigger) ? int'(ctrl.fast_speed) : 1;
                    mv = quad_turn[{quad_prev, q}] * spd * (1 << res_shift[kind]);
                    raw_pos = raw_pos + 18'(mv);
                    if (detent_masks[kind][q])
                    begin
                        bumped = det_cnt + 5'd1;
                        step_stamp_prev = step_stamp;
                        step_stamp = it.now_ms;
                        ext_pos = raw_pos[17:2];
                        det_cnt = (bumped < ctrl.detent_count_max) ? bumped[3:0]
                                                                   : ctrl.detent_count_max;
                    end
                    quad_prev = q;
                end
                pos = ext_pos;
                rep = rep_pos;
                if (pos != rep)
                begin
                    r.moved = 1'b1;
                    d = pos - rep;
                    delta_sum = delta_sum + 32'(int'(d));
                    reach = int'(pos) + 2 * int'(d);
                    if ((d > 0 && reach > int'(ctrl.position_limit)) ||
                        (d < 0 && reach < -int'(ctrl.position_limit)))
                    begin
                        raw_pos[17:2] = '0;
                        ext_pos = '0;
                        pos = '0;
                        r.limit_reset = 1'b1;
                    end
                    rep_pos = pos;
                end
            end
            CMD_READ:
            begin
                r.delta = delta_sum;
                delta_sum = '0;
            end
            CMD_ZERO:
            begin
                raw_pos[17:2] = '0;
                ext_pos = '0;
            end
            default: ;
        endcase
        r.position = ext_pos;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
        mismatches++;
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic program_registers(input cfg_t c);
        write_reg(REG_ENCODER_TYPE, 16'(c.encoder_type));
        write_reg(REG_FAST_TRIGGER, 16'(c.fast_trigger));
        write_reg(REG_FAST_SPEED, 16'(c.fast_speed));
        write_reg(REG_POSITION_LIMIT, 16'(c.position_limit));
        write_reg(REG_DECAY_MS, c.decay_ms);
        write_reg(REG_IDLE_MS, c.idle_ms);
        write_reg(REG_DETENT_COUNT_MAX, 16'(c.detent_count_max));
        cfg_we <= 1'b0;
        ctrl = c;
    endtask

    task automatic send_item(input item_t it, input logic known, input result_t want);
        int gap;
        if ($urandom_range(0, 15) == 0)
            sender_run = !sender_run;
        gap = (eager_left > 0 || sender_run) ? 0 : $urandom_range(0, 11);
        if (eager_left > 0)
            eager_left--;
        typed_answers.push_back('{known, want});
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= it.command;
        pin_a <= it.pin_a;
        pin_b <= it.pin_b;
        now_ms <= it.now_ms;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0 || typed_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        int   sent;
        int   kind;
        int   steps;
        int   pace;
        logic cw;
        logic flip;
        sent = 0;
        if ($urandom_range(0, 3) == 0)
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        while (sent < count)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // a turn of the knob, quick or slow, with an occasional bounce back
                steps = $urandom_range(1, 24);
                cw = $urandom_range(0, 1);
                pace = ($urandom_range(0, 3) == 0) ? 60 : 8;
                repeat (steps)
                begin
                    flip = ($urandom_range(0, 9) == 0);
                    cur_q = (cw ^ flip) ? cw_next[cur_q] : ccw_next[cur_q];
                    wall_ms = wall_ms + $urandom_range(0, pace);
                    send_item('{CMD_POLL, ~cur_q[0], ~cur_q[1], wall_ms}, 1'b0, NO_CHANGE);
                    sent++;
                end
            end
            else if (kind < 80)
            begin
                send_item('{CMD_READ, 1'($urandom), 1'($urandom), wall_ms}, 1'b0, NO_CHANGE);
                sent++;
            end
            else if (kind < 85)
            begin
                send_item('{CMD_ZERO, 1'($urandom), 1'($urandom), wall_ms}, 1'b0, NO_CHANGE);
                sent++;
            end
            else if (kind < 87)
            begin
                send_item('{CMD_UNUSED, 1'($urandom), 1'($urandom), $urandom}, 1'b0,
                          NO_CHANGE);
                sent++;
            end
            else
            begin
                // noise on the pins, or a long quiet spell that clears the counter
                cur_q = 2'($urandom);
                if (kind < 94)
                    wall_ms = wall_ms + $urandom_range(0, 1000);
                else if ($urandom_range(0, 1) == 0)
                    wall_ms = wall_ms + $urandom_range(400, 70000);
                else
                    wall_ms = wall_ms + $urandom;
                send_item('{CMD_POLL, ~cur_q[0], ~cur_q[1], wall_ms}, 1'b0, NO_CHANGE);
                sent++;
            end
        end
    endtask

    // predict at acceptance of each input item
    always @(posedge clk)
    begin
        note_t   note;
        result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            note = typed_answers.pop_front();
            r = advance_encoder('{command, pin_a, pin_b, now_ms});
            pending_readings.push_back(note.known ? note.want : r);
        end
    end

    // compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin
        result_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("result with nothing pending", position, 0);
            else
            begin
                due = pending_readings.pop_front();
                if (position !== due.position)
                    report_mismatch("position", position, $signed(due.position));
                if (delta !== due.delta)
                    report_mismatch("delta", delta, $signed(due.delta));
                if (moved !== due.moved)
                    report_mismatch("moved", moved, due.moved);
                if (limit_reset !== due.limit_reset)
                    report_mismatch("limit_reset", limit_reset, due.limit_reset);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stalls, bursts of constant ready, one long hold-off
    initial
    begin
        int hold;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                recv_run = !recv_run;
            if (hold_off_req)
            begin
                hold = 80;
                hold_off_req = 1'b0;
            end
            else
                hold = recv_run ? 0 : $urandom_range(0, 11);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        row_t rows [19];
        cfg_t fixed_settings [5];
        cfg_t setting;
        rows = '{
            '{'{CMD_POLL,   1'b1, 1'b1, 32'd0},          1'b1, NO_CHANGE},
            '{'{CMD_READ,   1'b1, 1'b1, 32'd0},          1'b1, NO_CHANGE},
            '{'{CMD_UNUSED, 1'b0, 1'b0, 32'hFFFF_FFFF},  1'b1, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b0, 32'd10},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b0, 1'b0, 32'd20},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b0, 1'b1, 32'd30},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b1, 32'd40},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b0, 32'd45},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b0, 1'b0, 32'd50},         1'b0, NO_CHANGE},
            '{'{CMD_READ,   1'b0, 1'b0, 32'd50},         1'b0, NO_CHANGE},
            // zeroing leaves the reported position, next poll sees the jump
            '{'{CMD_ZERO,   1'b0, 1'b0, 32'd55},         1'b1, NO_CHANGE},
            '{'{CMD_POLL,   1'b0, 1'b0, 32'd60},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b0, 32'd70},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b1, 32'd80},         1'b0, NO_CHANGE},
            // diagonal jump onto a detent: no step, but still a detent
            '{'{CMD_POLL,   1'b0, 1'b0, 32'd90},         1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b1, 1'b1, 32'hFFFF_FFFF},  1'b0, NO_CHANGE},
            '{'{CMD_POLL,   1'b0, 1'b1, 32'd0},          1'b0, NO_CHANGE},
            '{'{CMD_READ,   1'b1, 1'b1, 32'd0},          1'b0, NO_CHANGE},
            '{'{CMD_UNUSED, 1'b1, 1'b1, 32'd0},          1'b0, NO_CHANGE}
        };
        fixed_settings = '{
            '{3'd0, 4'd0,  4'd15, 15'd32767, 16'd1,     16'd65535, 4'd15},
            '{3'd1, 4'd15, 4'd1,  15'd1,     16'd65535, 16'd1,     4'd1},
            '{3'd3, 4'd2,  4'd7,  15'd40,    16'd20,    16'd300,   4'd8},
            '{3'd4, 4'd1,  4'd3,  15'd100,   16'd50,    16'd200,   4'd15},
            '{3'd7, 4'd0,  4'd15, 15'd5,     16'd10,    16'd65535, 4'd4}
        };
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_item(rows[i].stim, rows[i].known, rows[i].want);
        cur_q = 2'd1;
        wall_ms = '0;
        run_random(150);

        for (int p = 1; p < 8; p++)
        begin
            wait_drained();
            if (p <= 5)
                setting = fixed_settings[p - 1];
            else
            begin
                setting.encoder_type = 3'($urandom_range(0, 7));
                setting.fast_trigger = 4'($urandom_range(0, 15));
                setting.fast_speed = 4'($urandom_range(1, 15));
                setting.position_limit = ($urandom_range(0, 1) == 0) ?
                                         15'($urandom_range(1, 300)) :
                                         15'($urandom_range(1, 32767));
                setting.decay_ms = 16'($urandom_range(1, ($urandom_range(0, 1) == 0) ?
                                                         200 : 65535));
                setting.idle_ms = 16'($urandom_range(1, ($urandom_range(0, 1) == 0) ?
                                                        1000 : 65535));
                setting.detent_count_max = 4'($urandom_range(1, 15));
            end
            program_registers(setting);
            if (p == 2)
            begin
                // results held back while items keep coming
                hold_off_req = 1'b1;
                eager_left = 40;
            end
            run_random(155);
        end

        wait_drained();
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
sv/qdda_pkg.sv
sv/qdda_cfg.sv
sv/qdda_step.sv
sv/quadrature_detent_decoder_accel.sv
verif/tb_quadrature_detent_decoder_accel.sv
